/* rtl/core/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [2:0] {
    K_NORM, K_ADD, K_SUB, K_MUL, K_DIV, K_EQ, K_LESS, K_NONE
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK, ST_ZERO_DEN, ST_DIV_ZERO, ST_OVERFLOW
  } status_t;

  typedef enum logic [1:0] {
    UOP_MUL, UOP_GCD, UOP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

endpackage

/* rtl/core/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// rational ALU with gcd reduction on a shared iterative unit
// ----------------------------------------------------------------------------
// Raise start with kind and both fractions; the beat is taken when busy is low.
// busy stays high until the result beat, which sits on result_num, result_den,
// compare_flag and status for one cycle with done high; a new start may be
// given in that same cycle. The receiver cannot stall.
// Each operand is reduced (one gcd and two divides, skipped for a zero
// numerator), then up to three products are formed and, for add, sub, mul
// and div, the result is reduced again. All of these run on the shared unit
// at PW = 2*WIDTH bits, one step per cycle. A zero denominator and kind 7
// give their result beat in the cycle right after the accepting edge, and
// busy never rises.
// Reset returns the sequencer and the shared unit to idle with no result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] lhs_num,
  input  logic signed [31:0] lhs_den,
  input  logic signed [31:0] rhs_num,
  input  logic signed [31:0] rhs_den,
  output logic               done,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output logic               compare_flag,
  output logic [1:0]         status
);

  localparam int PW = 2 * WIDTH;
  localparam logic [PW-1:0] HALF = PW'(1) << (WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_G, S_DN, S_DD, S_RET, S_MI, S_MW
  } state_t;
  typedef enum logic [1:0] {R_A, R_B, R_R} ret_t;

  state_t        state;
  ret_t          ret;
  kind_t         kind_r;
  logic          an, bn, rn;
  logic [PW-1:0] am, ad, bm, bd, rm, rd, g;
  logic [PW-1:0] p0, p1, p2;
  logic [1:0]    mi;

  unit_req_t     ureq;
  logic [PW-1:0] ua, ub;
  logic          udone;
  logic [PW-1:0] uy;

  rau_unit #(.PW(PW)) u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .a    (ua),
    .b    (ub),
    .done (udone),
    .y    (uy)
  );

  function automatic logic [PW-1:0] mag_of(input logic [WIDTH-1:0] w);
    logic [WIDTH-1:0] m;
    m = w[WIDTH-1] ? (~w + 1'b1) : w;
    return {{(PW-WIDTH){1'b0}}, m};
  endfunction

  logic [PW-1:0] lnm, ldm, rnm, rdm;
  logic          lneg, rneg;
  assign lnm  = mag_of(lhs_num[WIDTH-1:0]);
  assign ldm  = mag_of(lhs_den[WIDTH-1:0]);
  assign rnm  = mag_of(rhs_num[WIDTH-1:0]);
  assign rdm  = mag_of(rhs_den[WIDTH-1:0]);
  assign lneg = lhs_num[WIDTH-1] ^ lhs_den[WIDTH-1];
  assign rneg = rhs_num[WIDTH-1] ^ rhs_den[WIDTH-1];

  // saturation of the reduced result
  logic          num_ovf, den_ovf;
  logic [PW-1:0] mag_s, den_s, num_s;
  always_comb begin
    num_ovf = rn ? (rm > HALF) : (rm > HALF - 1'b1);
    den_ovf = rd > HALF - 1'b1;
    mag_s   = num_ovf ? (rn ? HALF : HALF - 1'b1) : rm;
    den_s   = den_ovf ? HALF - 1'b1 : rd;
    num_s   = rn ? (~mag_s + 1'b1) : mag_s;
  end

  // signed-magnitude sum of the cross products
  logic          bneg_eff, sn;
  logic [PW-1:0] sm;
  always_comb begin
    bneg_eff = (kind_r == K_ADD) ? bn : (bm != '0 && !bn);
    if (an == bneg_eff) begin
      sn = an;
      sm = p0 + p1;
    end else if (p0 >= p1) begin
      sn = an;
      sm = p0 - p1;
    end else begin
      sn = bneg_eff;
      sm = p1 - p0;
    end
    if (sm == '0) sn = 1'b0;
  end

  logic [PW-1:0] mul_a, mul_b;
  always_comb begin
    case (mi)
      2'd0:    begin mul_a = am; mul_b = (kind_r == K_MUL) ? bm : bd; end
      2'd1:    begin mul_a = bm; mul_b = ad; end
      default: begin mul_a = ad; mul_b = (kind_r == K_DIV) ? bm : bd; end
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    done       <= 1'b0;
    ureq.start <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      ureq.op <= UOP_MUL;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_r <= kind_t'(kind);
            an <= lneg; am <= lnm; ad <= ldm;
            bn <= rneg; bm <= rnm; bd <= rdm;
            rn <= lneg; rm <= lnm; rd <= ldm;
            ret <= R_A;
            if (kind_t'(kind) == K_NONE || ldm == '0
                || (kind_t'(kind) != K_NORM && rdm == '0)) begin
              result_num   <= '0;
              result_den   <= 31'd1;
              compare_flag <= 1'b0;
              status       <= (kind_t'(kind) == K_NONE) ? ST_OK : ST_ZERO_DEN;
              done         <= 1'b1;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (rm == '0) begin
            rn    <= 1'b0;
            rd    <= PW'(1);
            state <= S_RET;
          end else begin
            ureq.start <= 1'b1;
            ureq.op    <= UOP_GCD;
            ua <= rm;
            ub <= rd;
            state <= S_G;
          end
        end
        S_G: begin
          if (udone) begin
            g <= uy;
            ureq.start <= 1'b1;
            ureq.op    <= UOP_DIV;
            ua <= rm;
            ub <= uy;
            state <= S_DN;
          end
        end
        S_DN: begin
          if (udone) begin
            rm <= uy;
            ureq.start <= 1'b1;
            ureq.op    <= UOP_DIV;
            ua <= rd;
            ub <= g;
            state <= S_DD;
          end
        end
        S_DD: begin
          if (udone) begin
            rd    <= uy;
            state <= S_RET;
          end
        end
        S_RET: begin
          case (ret)
            R_A: begin
              an <= rn; am <= rm; ad <= rd;
              if (kind_r == K_NORM) begin
                result_num   <= 32'(signed'(num_s[WIDTH-1:0]));
                result_den   <= 31'(den_s[WIDTH-2:0]);
                compare_flag <= 1'b0;
                status       <= (num_ovf || den_ovf) ? ST_OVERFLOW : ST_OK;
                done         <= 1'b1;
                state        <= S_IDLE;
              end else begin
                rn <= bn; rm <= bm; rd <= bd;
                ret   <= R_B;
                state <= S_RED;
              end
            end
            R_B: begin
              bn <= rn; bm <= rm; bd <= rd;
              mi <= 2'd0;
              if (kind_r == K_EQ || (kind_r == K_DIV && rm == '0)) begin
                result_num   <= '0;
                result_den   <= 31'd1;
                compare_flag <= (kind_r == K_EQ) && an == rn && am == rm && ad == rd;
                status       <= (kind_r == K_EQ) ? ST_OK : ST_DIV_ZERO;
                done         <= 1'b1;
                state        <= S_IDLE;
              end else begin
                state <= S_MI;
              end
            end
            default: begin
              result_num   <= 32'(signed'(num_s[WIDTH-1:0]));
              result_den   <= 31'(den_s[WIDTH-2:0]);
              compare_flag <= 1'b0;
              status       <= (num_ovf || den_ovf) ? ST_OVERFLOW : ST_OK;
              done         <= 1'b1;
              state        <= S_IDLE;
            end
          endcase
        end
        S_MI: begin
          if (mi == 2'd3) begin
            // all products ready
            if (kind_r == K_LESS) begin
              result_num   <= '0;
              result_den   <= 31'd1;
              compare_flag <= sn && sm != '0;
              status       <= ST_OK;
              done         <= 1'b1;
              state        <= S_IDLE;
            end else begin
              if (kind_r == K_MUL || kind_r == K_DIV) begin
                rn <= an ^ bn;
                rm <= p0;
              end else begin
                rn <= sn;
                rm <= sm;
              end
              rd    <= p2;
              ret   <= R_R;
              state <= S_RED;
            end
          end else begin
            ureq.start <= 1'b1;
            ureq.op    <= UOP_MUL;
            ua <= mul_a;
            ub <= mul_b;
            state <= S_MW;
          end
        end
        S_MW: begin
          if (udone) begin
            case (mi)
              2'd0:    p0 <= uy;
              2'd1:    p1 <= uy;
              default: p2 <= uy;
            endcase
            mi    <= mi + 1'b1;
            state <= S_MI;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // zero denominators and kind 7 answer straight from idle, so the beat may follow a start
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result beat without an item in progress");

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind_t'(kind) != K_NONE && ldm != '0
    && (kind_t'(kind) == K_NORM || rdm != '0) |=> busy)
    else $error("accepted item did not raise busy");

  a_err_plain: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK && status != ST_OVERFLOW
    |-> result_num == '0 && result_den == 31'd1 && !compare_flag)
    else $error("error beat carries a value");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> result_den != '0)
    else $error("zero result denominator");

endmodule

/* rtl/core/rau_unit.sv */
// ----------------------------------------------------------------------------
// rau_unit
// shared iterative unit: shift-add multiply, binary gcd, restoring divide
// ----------------------------------------------------------------------------
module rau_unit import rau_pkg::*; #(
  parameter int PW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  unit_req_t     req,
  input  logic [PW-1:0] a,
  input  logic [PW-1:0] b,
  output logic          done,
  output logic [PW-1:0] y
);

  localparam int KW = $clog2(PW + 1);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_GCD, U_DIV} ustate_t;

  ustate_t       state;
  logic [PW-1:0] u;
  logic [PW-1:0] v;
  logic [PW-1:0] acc;
  logic [PW:0]   r;
  logic [KW-1:0] k;

  logic [PW:0]   rs;
  logic [PW:0]   rdiff;
  logic          ge;

  assign rs    = {r[PW-1:0], u[PW-1]};
  assign ge    = rs >= {1'b0, v};
  assign rdiff = rs - {1'b0, v};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= U_IDLE;
    end else begin
      case (state)
        U_IDLE: begin
          if (req.start) begin
            u   <= a;
            v   <= b;
            acc <= '0;
            r   <= '0;
            k   <= '0;
            case (req.op)
              UOP_MUL: state <= U_MUL;
              UOP_GCD: state <= U_GCD;
              UOP_DIV: state <= U_DIV;
              default: state <= U_IDLE;
            endcase
          end
        end
        U_MUL: begin
          if (v == '0) begin
            y     <= acc;
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            if (v[0]) acc <= acc + u;
            u <= u << 1;
            v <= v >> 1;
          end
        end
        U_GCD: begin
          if (u == '0 || v == '0) begin
            y     <= (u | v) << k;
            done  <= 1'b1;
            state <= U_IDLE;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        U_DIV: begin
          // k counts quotient bits
          if (k == KW'(PW)) begin
            y     <= u;
            done  <= 1'b1;
            state <= U_IDLE;
          end else begin
            r <= ge ? rdiff : rs;
            u <= {u[PW-2:0], ge};
            k <= k + 1'b1;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

/* tb/rational_arithmetic_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// drives operation beats from a directed table and then at random, predicts or
// looks up each reduced fraction, flag and status, checks every result beat
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb import rau_pkg::*; ;

  localparam int W = 32;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] ln, ld, rn, rd;
  } op_beat_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               flag;
    logic [1:0]         st;
  } answer_t;

  typedef struct {
    op_beat_t op;
    bit       typed;
    answer_t  ans;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] kind = '0;
  logic signed [31:0] lhs_num = '0, lhs_den = '0, rhs_num = '0, rhs_den = '0;
  logic busy, done, compare_flag;
  logic signed [31:0] result_num;
  logic [30:0] result_den;
  logic [1:0] status;

  answer_t pending_answers[$];
  bit failed = 1'b0;
  int send_idle_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rational_arithmetic_unit #(.WIDTH(W)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .lhs_num(lhs_num), .lhs_den(lhs_den), .rhs_num(rhs_num), .rhs_den(rhs_den),
    .done(done), .result_num(result_num), .result_den(result_den),
    .compare_flag(compare_flag), .status(status)
  );

  function automatic logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
    logic [127:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // sign/magnitude fraction in lowest terms, den > 0, zero as 0/1
  function automatic void lowest(inout bit neg, inout logic [127:0] mag,
                                 inout logic [127:0] den);
    logic [127:0] g;
    if (mag == 0) begin
      neg = 0;
      den = 1;
    end else begin
      g = gcd128(mag, den);
      mag = mag / g;
      den = den / g;
    end
  endfunction

  function automatic void sign_mag(logic signed [31:0] v, output bit neg,
                                   output logic [127:0] mag);
    neg = v[31];
    mag = v[31] ? 128'(-64'(v)) : 128'(v);
  endfunction

  function automatic answer_t plain(logic flag, status_t st);
    answer_t a;
    a.num = 0;
    a.den = 1;
    a.flag = flag;
    a.st = st;
    return a;
  endfunction

  function automatic answer_t saturate(bit neg, logic [127:0] mag, logic [127:0] den);
    answer_t a;
    logic [127:0] half;
    half = 128'(1) << (W - 1);
    a.flag = 0;
    a.st = ST_OK;
    if (neg ? (mag > half) : (mag > half - 1)) begin
      mag = neg ? half : half - 1;
      a.st = ST_OVERFLOW;
    end
    if (den > half - 1) begin
      den = half - 1;
      a.st = ST_OVERFLOW;
    end
    a.num = neg ? -32'(mag) : 32'(mag);
    a.den = 31'(den);
    return a;
  endfunction

  function automatic answer_t predict_fraction(op_beat_t op);
    bit an, ad, bn, bd, rn, sn;
    logic [127:0] am, adm, bm, bdm, x, y, m;
    if (op.kind == K_NONE) return plain(0, ST_OK);
    sign_mag(op.ln, an, am);
    sign_mag(op.ld, ad, adm);
    if (adm == 0) return plain(0, ST_ZERO_DEN);
    an = an ^ ad;
    lowest(an, am, adm);
    if (op.kind == K_NORM) return saturate(an, am, adm);
    sign_mag(op.rn, bn, bm);
    sign_mag(op.rd, bd, bdm);
    if (bdm == 0) return plain(0, ST_ZERO_DEN);
    bn = bn ^ bd;
    lowest(bn, bm, bdm);
    case (op.kind)
      K_ADD, K_SUB, K_LESS: begin
        sn = (op.kind == K_ADD) ? bn : (bm != 0 && !bn);
        x = am * bdm;
        y = bm * adm;
        if (an == sn) begin
          rn = an;
          m = x + y;
        end else if (x >= y) begin
          rn = an;
          m = x - y;
        end else begin
          rn = sn;
          m = y - x;
        end
        if (m == 0) rn = 0;
        if (op.kind == K_LESS) return plain(rn && m != 0, ST_OK);
        x = adm * bdm;
        lowest(rn, m, x);
        return saturate(rn, m, x);
      end
      K_MUL: begin
        rn = an ^ bn;
        m = am * bm;
        x = adm * bdm;
        lowest(rn, m, x);
        return saturate(rn, m, x);
      end
      K_DIV: begin
        if (bm == 0) return plain(0, ST_DIV_ZERO);
        rn = an ^ bn;
        m = am * bdm;
        x = adm * bm;
        lowest(rn, m, x);
        return saturate(rn, m, x);
      end
      default: return plain(an == bn && am == bm && adm == bdm, ST_OK);
    endcase
  endfunction

  // result beats are taken at the edge that ends the done cycle
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %0d/%0d f%0d s%0d",
                 $time, result_num, result_den, compare_flag, status);
        failed = 1'b1;
      end else begin
        e = pending_answers.pop_front();
        if (result_num !== e.num) begin
          $display("%0t: result_num expected %0d actual %0d", $time, e.num, result_num);
          failed = 1'b1;
        end
        if (result_den !== e.den) begin
          $display("%0t: result_den expected %0d actual %0d", $time, e.den, result_den);
          failed = 1'b1;
        end
        if (compare_flag !== e.flag) begin
          $display("%0t: compare_flag expected %0d actual %0d", $time, e.flag,
                   compare_flag);
          failed = 1'b1;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          failed = 1'b1;
        end
      end
    end
  end

  // start stays high from one beat to the next unless the sender idles
  task automatic send_op(op_beat_t op, answer_t ans);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= op.kind;
    lhs_num <= op.ln;
    lhs_den <= op.ld;
    rhs_num <= op.rn;
    rhs_den <= op.rd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(ans);
  endtask

  // mostly small magnitudes so reductions bite, some full-range values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(64)) - 32;
      2: return $signed($urandom_range(2000)) - 1000;
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      4: return $signed(32'($urandom_range(1000)) * 32'($urandom_range(360)));
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  function automatic op_beat_t random_op();
    op_beat_t op;
    op.kind = ($urandom_range(40) == 0) ? K_NONE : 3'($urandom_range(6));
    op.ln = pick_value();
    op.ld = pick_value();
    op.rn = pick_value();
    op.rd = pick_value();
    if ($urandom_range(15) == 0) op.ld = 0;
    if ($urandom_range(15) == 0) op.rd = 0;
    if ($urandom_range(10) == 0) op.rn = 0;
    if (op.kind == K_EQ && $urandom_range(1)) begin
      op.rn = op.ln * 3;
      op.rd = op.ld * 3;
    end
    return op;
  endfunction

  localparam int NUM_ROWS = 20;
  table_row_t directed[NUM_ROWS] = '{
    '{'{K_NORM, 32'sd6, -32'sd4, 0, 0}, 1, '{-32'sd3, 31'd2, 0, ST_OK}},
    '{'{K_NORM, 32'sh80000000, -32'sd1, 5, 7}, 1,
      '{32'sh7fffffff, 31'd1, 0, ST_OVERFLOW}},
    '{'{K_NORM, 32'sd5, 0, 1, 1}, 1, '{0, 31'd1, 0, ST_ZERO_DEN}},
    '{'{K_NORM, 32'sd0, -32'sd9, 1, 0}, 1, '{0, 31'd1, 0, ST_OK}},
    '{'{K_NORM, 32'sd1, 32'sh80000000, 0, 0}, 1,
      '{-32'sd1, 31'h7fffffff, 0, ST_OVERFLOW}},
    '{'{K_ADD, 32'sd1, 0, 1, 1}, 1, '{0, 31'd1, 0, ST_ZERO_DEN}},
    '{'{K_ADD, 32'sd1, 32'sd2, 1, 0}, 1, '{0, 31'd1, 0, ST_ZERO_DEN}},
    '{'{K_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3}, 1, '{32'sd5, 31'd6, 0, ST_OK}},
    '{'{K_ADD, 32'sh7fffffff, 32'sd1, 32'sh7fffffff, 32'sd1}, 1,
      '{32'sh7fffffff, 31'd1, 0, ST_OVERFLOW}},
    '{'{K_SUB, 32'sh80000000, 32'sd1, 32'sh7fffffff, 32'sd1}, 1,
      '{32'sh80000000, 31'd1, 0, ST_OVERFLOW}},
    '{'{K_SUB, 32'sd3, 32'sd4, 32'sd3, 32'sd4}, 1, '{0, 31'd1, 0, ST_OK}},
    '{'{K_MUL, 32'sh7fffffff, 32'sh7ffffffe, 32'sh7ffffffe, 32'sh7fffffff}, 0,
      '{0, 0, 0, 0}},
    '{'{K_MUL, 32'sh80000000, 32'sd3, 32'sh80000000, 32'sd7}, 0, '{0, 0, 0, 0}},
    '{'{K_DIV, 32'sd1, 32'sd2, 0, 32'sd5}, 1, '{0, 31'd1, 0, ST_DIV_ZERO}},
    '{'{K_DIV, -32'sd3, 32'sd4, 32'sd9, -32'sd8}, 1, '{32'sd2, 31'd3, 0, ST_OK}},
    '{'{K_EQ, 32'sd2, 32'sd4, -32'sd3, -32'sd6}, 1, '{0, 31'd1, 1, ST_OK}},
    '{'{K_EQ, 32'sd2, 32'sd4, 32'sd3, -32'sd6}, 1, '{0, 31'd1, 0, ST_OK}},
    '{'{K_LESS, 32'sh80000000, 32'sd1, 32'sh7fffffff, 32'sd1}, 1,
      '{0, 31'd1, 1, ST_OK}},
    '{'{K_LESS, 32'sd1, 32'sd3, 32'sd1, 32'sd3}, 1, '{0, 31'd1, 0, ST_OK}},
    '{'{K_NONE, 32'sd7, 0, 32'sd7, 0}, 1, '{0, 31'd1, 0, ST_OK}}
  };

  initial begin
    answer_t a;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      a = predict_fraction(directed[i].op);
      send_op(directed[i].op, directed[i].typed ? directed[i].ans : a);
    end
    for (int i = 0; i < 750; i++) begin
      if (i == 0) send_idle_pct = 37;
      else if (i == 250) send_idle_pct = 65;
      else if (i == 500) send_idle_pct = 0;
      begin
        op_beat_t op;
        op = random_op();
        send_op(op, predict_fraction(op));
      end
    end
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // ~770 beats plus sender gaps, with wide margin
  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
